>>> hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Segmented particle store package
// Types, register indexes, status and function codes shared by the store.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_REGS  = 4;
    localparam int BOUND_MAX = 2047;

    typedef logic [10:0]                t_bound;
    typedef t_bound [NUM_REGS-1:0]      t_cfg;
    typedef logic [1:0]                 t_status;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEG1 = 2'd0;
    localparam logic [1:0] REG_SEG2 = 2'd1;
    localparam logic [1:0] REG_SEG3 = 2'd2;
    localparam logic [1:0] REG_END  = 2'd3;

    localparam t_cfg CFG_RESET = {11'd1024, 11'd768, 11'd512, 11'd256};

    // Result status codes.
    localparam t_status STAT_DONE = 2'd0;
    localparam t_status STAT_FULL = 2'd1;
    localparam t_status STAT_BAD  = 2'd2;

    // Item function codes.
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_CUT = 1'b1;

    // Subtrahends that make the shared subtractor count up or down by one.
    localparam logic [11:0] ALU_B_INC = 12'hFFF;
    localparam logic [11:0] ALU_B_DEC = 12'h001;

    typedef struct packed {
        logic [11:0] a;
        logic [11:0] b;
    } t_alu_req;

    typedef struct packed {
        t_bound res;
        logic   lt;
    } t_alu_rsp;

    typedef struct packed {
        t_status status;
        t_bound  fill_end;
    } t_result;

endpackage

>>> hdl/sps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int WIDTH = 384,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sps_alu.sv
// ----------------------------------------------------------------------------
// Shared subtractor
// Gives a - b and the borrow, used for every bound check and pointer step.
// ----------------------------------------------------------------------------
module sps_alu (
    input  sps_pkg::t_alu_req i_req,
    output sps_pkg::t_alu_rsp o_rsp
);

    import sps_pkg::*;

    logic [12:0] diff;

    assign diff      = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.lt  = diff[12];
    assign o_rsp.res = diff[10:0];

endmodule

>>> hdl/sps_seq.sv
// ----------------------------------------------------------------------------
// Store sequencer
// Fill pointers and the step control that drives the subtractor and the RAM.
// ----------------------------------------------------------------------------
module sps_seq #(
    parameter int NUM_SPECIES = 4,
    parameter int DIMS        = 3,
    parameter int CAPACITY    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sps_pkg::t_cfg               i_cfg,
    input  logic                        i_rewind,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [1:0]                  i_species,
    input  logic [9:0]                  i_index,
    input  logic [128*DIMS-1:0]         i_rec,
    output logic                        o_done,
    output sps_pkg::t_result            o_res,
    output logic [128*DIMS-1:0]         o_rec,
    input  logic                        i_take,
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [128*DIMS-1:0]         o_ram_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  logic [128*DIMS-1:0]         i_ram_rdata
);

    import sps_pkg::*;

    localparam int AW         = $clog2(CAPACITY);
    localparam int RW         = 2 * WORD_W * DIMS;
    localparam int SW         = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
    localparam int CAP_CLIP_I = (CAPACITY > BOUND_MAX) ? BOUND_MAX : CAPACITY;
    localparam t_bound CAP_CLIP = t_bound'(CAP_CLIP_I);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK1 = 3'd1;
    localparam logic [2:0] ST_CHK2 = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_RDL  = 3'd4;
    localparam logic [2:0] ST_WR   = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    function automatic t_bound clamp(t_bound v);
        return (v > CAP_CLIP) ? CAP_CLIP : v;
    endfunction

    function automatic t_bound seg_first(t_cfg cfg, logic [1:0] s);
        t_bound v;
        v = '0;
        if (s != 2'd0) begin
            v = clamp(cfg[s - 2'd1]);
        end
        return v;
    endfunction

    function automatic t_bound seg_end(t_cfg cfg, logic [1:0] s);
        t_bound v;
        if ((32'(s) + 1 < NUM_SPECIES) && (s != REG_END)) begin
            v = clamp(cfg[s]);
        end else begin
            v = clamp(cfg[REG_END]);
        end
        return v;
    endfunction

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    t_bound        r_fill [NUM_SPECIES];
    logic          r_func;
    logic [1:0]    r_spc;
    logic [9:0]    r_slot;
    logic [RW-1:0] r_rec;
    logic [RW-1:0] r_out_rec;
    t_bound        r_f;
    t_status       r_status;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic     accept;
    logic     spc_ok;
    t_bound   first_sel;
    t_bound   end_sel;

    sps_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || i_rewind;
    assign spc_ok     = 32'(i_species) < NUM_SPECIES;
    assign first_sel  = seg_first(i_cfg, r_spc);
    assign end_sel    = seg_end(i_cfg, r_spc);

    always_comb begin
        alu_req.a = {1'b0, r_f};
        alu_req.b = '0;
        case (r_state)
            ST_CHK1: begin
                alu_req.a = (r_func == FUNC_CUT) ? {2'b00, r_slot} : {1'b0, r_f};
                alu_req.b = {1'b0, (r_func == FUNC_CUT) ? first_sel : end_sel};
            end
            ST_CHK2: begin
                alu_req.a = {2'b00, r_slot};
                alu_req.b = {1'b0, r_f};
            end
            ST_STEP: begin
                alu_req.b = (r_func == FUNC_CUT) ? ALU_B_DEC : ALU_B_INC;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = spc_ok ? ST_CHK1 : ST_DONE;
                end
            end
            ST_CHK1: begin
                if (r_func == FUNC_CUT) begin
                    n_state = alu_rsp.lt ? ST_DONE : ST_CHK2;
                end else begin
                    n_state = alu_rsp.lt ? ST_STEP : ST_DONE;
                end
            end
            ST_CHK2: n_state = alu_rsp.lt ? ST_STEP : ST_DONE;
            ST_STEP: n_state = (r_func == FUNC_CUT) ? ST_RDL : ST_DONE;
            ST_RDL:  n_state = ST_WR;
            ST_WR:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int s = 0; s < NUM_SPECIES; s++) begin
                r_fill[s] <= seg_first(CFG_RESET, 2'(s));
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_func    <= i_func;
                        r_spc     <= i_species;
                        r_slot    <= i_index;
                        r_rec     <= i_rec;
                        r_out_rec <= '0;
                        if (spc_ok) begin
                            r_f      <= r_fill[i_species[SW-1:0]];
                            r_status <= STAT_DONE;
                        end else begin
                            r_f      <= '0;
                            r_status <= (i_func == FUNC_CUT) ? STAT_BAD : STAT_FULL;
                        end
                    end
                end
                ST_CHK1: begin
                    if (r_func == FUNC_CUT && alu_rsp.lt) begin
                        r_status <= STAT_BAD;
                    end else if (r_func == FUNC_ADD && !alu_rsp.lt) begin
                        r_status <= STAT_FULL;
                    end
                end
                ST_CHK2: begin
                    if (!alu_rsp.lt) begin
                        r_status <= STAT_BAD;
                    end
                end
                ST_STEP: begin
                    // Add counts the fill up; cut counts it down to the last slot.
                    r_f                   <= alu_rsp.res;
                    r_fill[r_spc[SW-1:0]] <= alu_rsp.res;
                end
                ST_RDL: begin
                    r_out_rec <= i_ram_rdata;
                end
                default: begin
                end
            endcase
            if (i_rewind) begin
                for (int s = 0; s < NUM_SPECIES; s++) begin
                    r_fill[s] <= seg_first(i_cfg, 2'(s));
                end
            end
        end
    end

    // An add writes the new record at the fill end; a cut writes the last
    // record, just read back, into the freed slot.
    assign o_ram_we    = (r_state == ST_STEP && r_func == FUNC_ADD) || (r_state == ST_WR);
    assign o_ram_waddr = (r_state == ST_STEP) ? AW'(r_f) : AW'(r_slot);
    assign o_ram_wdata = (r_state == ST_STEP) ? r_rec : i_ram_rdata;
    assign o_ram_raddr = (r_state == ST_RDL) ? AW'(r_f) : AW'(r_slot);

    assign o_done         = (r_state == ST_DONE);
    assign o_res.status   = r_status;
    assign o_res.fill_end = r_f;
    assign o_rec          = r_out_rec;

`ifndef SYNTH
    a_cut_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && r_func == FUNC_CUT) |-> ({1'b0, r_slot} < r_f))
        else $error("cut step entered with slot outside the filled range");

    a_flag_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_status != STAT_DONE) |-> (r_out_rec == '0))
        else $error("flagged result carries a record");

    // The fill pointers follow new segment bounds through the registered
    // rewind strobe, so the check rests while the rewind is pending.
    for (genvar g = 0; g < NUM_SPECIES; g++) begin : g_fill_chk
        a_fill_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !i_rewind |-> (r_fill[g] >= seg_first(i_cfg, 2'(g))))
            else $error("fill pointer fell below its segment start");
    end
`endif

endmodule

>>> hdl/segmented_particle_store_top.sv
// ----------------------------------------------------------------------------
// Segmented particle store
// Packed per-species particle records with append and swap-remove.
// ----------------------------------------------------------------------------
// The store holds CAPACITY particle records, each DIMS position words and
// DIMS velocity words, in one RAM split into up to four species segments
// whose bounds come from the configuration registers. Every item gives one
// result beat. Each add or cut runs to its end before the next item can
// be accepted: the sequencer runs each bound check and each fill pointer
// step through a single shared subtractor, and a cut reads the addressed
// slot and the last slot through the one RAM read port before writing one
// slot back. A configuration write rewinds every fill pointer and holds off
// the input while the rewind is pending. The RAM needs no clearing pass
// after reset.
module segmented_particle_store_top #(
    parameter int NUM_SPECIES = 4,
    parameter int DIMS        = 3,
    parameter int CAPACITY    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [1:0]  i_species,
    input  logic [9:0]  i_index,
    input  logic [63:0] i_pos_x,
    input  logic [63:0] i_pos_y,
    input  logic [63:0] i_pos_z,
    input  logic [63:0] i_vel_x,
    input  logic [63:0] i_vel_y,
    input  logic [63:0] i_vel_z,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_pos_x,
    output logic [63:0] o_out_pos_y,
    output logic [63:0] o_out_pos_z,
    output logic [63:0] o_out_vel_x,
    output logic [63:0] o_out_vel_y,
    output logic [63:0] o_out_vel_z,
    output logic [10:0] o_fill_end
);

    import sps_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int RW = 2 * WORD_W * DIMS;

    // Configuration registers and the rewind strobe that follows a write.
    t_cfg r_cfg;
    logic r_rewind;

    // Record as stored in one RAM word: positions low, velocities high.
    logic [RW-1:0]     in_rec;
    logic [WORD_W-1:0] in_pos [3];
    logic [WORD_W-1:0] in_vel [3];
    logic [WORD_W-1:0] res_pos [3];
    logic [WORD_W-1:0] res_vel [3];

    logic          done;
    logic          take;
    t_result       res;
    logic [RW-1:0] res_rec;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    // Output register: the result beat waits here while the sequencer goes on.
    logic              r_out_valid;
    t_status           r_status;
    t_bound            r_fill_end;
    logic [WORD_W-1:0] r_pos [3];
    logic [WORD_W-1:0] r_vel [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_rewind <= 1'b0;
        end else begin
            r_rewind <= i_cfg_we;
            if (i_cfg_we) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;
    assign in_vel[0] = i_vel_x;
    assign in_vel[1] = i_vel_y;
    assign in_vel[2] = i_vel_z;

    // Words of dimensions the store does not keep are dropped on add and
    // answered as zero.
    for (genvar d = 0; d < 3; d++) begin : g_dim
        if (d < DIMS) begin : g_used
            assign in_rec[WORD_W*d +: WORD_W]          = in_pos[d];
            assign in_rec[WORD_W*(DIMS+d) +: WORD_W]   = in_vel[d];
            assign res_pos[d] = res_rec[WORD_W*d +: WORD_W];
            assign res_vel[d] = res_rec[WORD_W*(DIMS+d) +: WORD_W];
        end else begin : g_unused
            assign res_pos[d] = '0;
            assign res_vel[d] = '0;
        end
    end

    sps_seq #(
        .NUM_SPECIES (NUM_SPECIES),
        .DIMS        (DIMS),
        .CAPACITY    (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rewind    (r_rewind),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_species   (i_species),
        .i_index     (i_index),
        .i_rec       (in_rec),
        .o_done      (done),
        .o_res       (res),
        .o_rec       (res_rec),
        .i_take      (take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    sps_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A finished result moves into the output register whenever that
    // register is empty or its beat is being taken in the same cycle.
    assign take = done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status   <= res.status;
            r_fill_end <= res.fill_end;
            for (int d = 0; d < 3; d++) begin
                r_pos[d] <= res_pos[d];
                r_vel[d] <= res_vel[d];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_fill_end  = r_fill_end;
    assign o_out_pos_x = r_pos[0];
    assign o_out_pos_y = r_pos[1];
    assign o_out_pos_z = r_pos[2];
    assign o_out_vel_x = r_vel[0];
    assign o_out_vel_y = r_vel[1];
    assign o_out_vel_z = r_vel[2];

endmodule

>>> verif/tb_segmented_particle_store_top.sv
// ----------------------------------------------------------------------------
// Segmented particle store testbench
// Drives add and cut beats into the store and checks every result beat.
// ----------------------------------------------------------------------------
// A directed table runs first. It covers the reset layout, the field
// extremes, the error statuses, empty and inverted segments, bounds above
// capacity and two species sharing slots. Random phases follow. Each phase
// rewrites all four segment registers and then sends a mix of appends and
// cuts. Most cuts aim inside the filled range so that records really move.
// A shadow copy of the store predicts every result beat. Both channels idle
// at random, except during one phase where they run back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segmented_particle_store_top;
    import sps_pkg::*;

    localparam int NUM_SPECIES = 4;
    localparam int DIMS        = 3;
    localparam int CAPACITY    = 1024;
    localparam int RAND_ITEMS  = 1480;
    localparam int CYCLE_LIMIT = 400000;
    // Idle cycles that separate the last result beat from a register
    // write. The block is already at rest once that beat has been taken.
    localparam int SETTLE_CYCLES = 8;

    // One request beat. Words 0..5 are pos x, y, z and then vel x, y, z.
    typedef struct packed {
        logic             func;
        logic [1:0]       species;
        logic [9:0]       index;
        logic [5:0][63:0] words;
    } t_particle_op;

    // One result beat, with the same word order as the request.
    typedef struct packed {
        t_status          status;
        logic [5:0][63:0] words;
        t_bound           fill_end;
    } t_store_reply;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} t_fill_pat;
    typedef enum logic [1:0] {LAY_RESET, LAY_PACKED, LAY_WILD, LAY_TOP} t_layout;

    // A directed row either writes one register or sends one beat. Rows
    // with 'typed' set carry their expected status and fill end. Their
    // record words are zero. The other rows are left to the shadow store.
    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] reg_sel;
        t_bound     reg_val;
        logic       func;
        logic [1:0] species;
        logic [9:0] index;
        t_fill_pat  pat;
        logic       typed;
        t_status    want_status;
        t_bound     want_fill;
    } t_dir_row;

    localparam int DIR_ROWS = 27;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Reset layout: species segments start at 0, 256, 512 and 768.
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd0, FILL_ZERO, 1'b1, STAT_BAD, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd0, 10'd0, FILL_ZERO, 1'b1, STAT_DONE, 11'd1},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd0, 10'd1023, FILL_ONES, 1'b1, STAT_DONE, 11'd2},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd0, 10'd0, FILL_RAND, 1'b1, STAT_DONE, 11'd3},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd1, 10'd0, FILL_RAND, 1'b1, STAT_DONE, 11'd257},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd2, 10'd0, FILL_ONES, 1'b1, STAT_DONE, 11'd513},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd3, 10'd0, FILL_RAND, 1'b1, STAT_DONE, 11'd769},
        // Cut at the fill end itself, at the top slot, and below the segment start.
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd3, FILL_ZERO, 1'b1, STAT_BAD, 11'd3},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd1023, FILL_ZERO, 1'b1, STAT_BAD, 11'd3},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd1, 10'd255, FILL_ZERO, 1'b1, STAT_BAD, 11'd257},
        // Swap-remove from the front. The last record of the species moves down.
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd0, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd1, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd0, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd3, 10'd768, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd2, 10'd512, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd1, 10'd256, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        // Species 0 gets [0,2). Species 1 is empty and species 2 inverted.
        // Species 3 covers [1,2047), taken as [1,1024), and so shares slot 1.
        '{ROW_CFG, REG_SEG1, 11'd2, FUNC_ADD, 2'd0, 10'd0, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_CFG, REG_SEG2, 11'd2, FUNC_ADD, 2'd0, 10'd0, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_CFG, REG_SEG3, 11'd1, FUNC_ADD, 2'd0, 10'd0, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_CFG, REG_END, 11'd2047, FUNC_ADD, 2'd0, 10'd0, FILL_ZERO, 1'b0, STAT_DONE, 11'd0},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd0, 10'd0, FILL_RAND, 1'b1, STAT_DONE, 11'd1},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd0, 10'd0, FILL_RAND, 1'b1, STAT_DONE, 11'd2},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd0, 10'd0, FILL_RAND, 1'b1, STAT_FULL, 11'd2},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd1, 10'd0, FILL_RAND, 1'b1, STAT_FULL, 11'd2},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd2, 10'd0, FILL_RAND, 1'b1, STAT_FULL, 11'd2},
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_ADD, 2'd3, 10'd0, FILL_RAND, 1'b1, STAT_DONE, 11'd2},
        // Species 3 has just overwritten slot 1, so species 0 gets that record back.
        '{ROW_ITEM, REG_SEG1, 11'd0, FUNC_CUT, 2'd0, 10'd1, FILL_ZERO, 1'b0, STAT_DONE, 11'd0}
    };

    localparam string WORD_NAME [6] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                                        "out_vel_x", "out_vel_y", "out_vel_z"};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = REG_SEG1;
    logic [10:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_func      = FUNC_ADD;
    logic [1:0]  i_species   = '0;
    logic [9:0]  i_index     = '0;
    logic [63:0] i_pos_x     = '0;
    logic [63:0] i_pos_y     = '0;
    logic [63:0] i_pos_z     = '0;
    logic [63:0] i_vel_x     = '0;
    logic [63:0] i_vel_y     = '0;
    logic [63:0] i_vel_z     = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_out_pos_x;
    logic [63:0] o_out_pos_y;
    logic [63:0] o_out_pos_z;
    logic [63:0] o_out_vel_x;
    logic [63:0] o_out_vel_y;
    logic [63:0] o_out_vel_z;
    logic [10:0] o_fill_end;

    // Shadow of the store: segment registers, fill pointers and records.
    t_cfg             cfg_shadow;
    t_bound           fill_ptr [NUM_SPECIES];
    logic [5:0][63:0] rec_mem  [CAPACITY];

    t_store_reply awaited [$];    // result beats still owed by the store
    int           mismatch_cnt = 0;
    int           cycle_cnt    = 0;
    int           stall_left   = 0;
    logic         no_idle      = 1'b0;

    segmented_particle_store_top #(
        .NUM_SPECIES (NUM_SPECIES),
        .DIMS        (DIMS),
        .CAPACITY    (CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_species   (i_species),
        .i_index     (i_index),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_vel_z     (i_vel_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_pos_x (o_out_pos_x),
        .o_out_pos_y (o_out_pos_y),
        .o_out_pos_z (o_out_pos_z),
        .o_out_vel_x (o_out_vel_x),
        .o_out_vel_y (o_out_vel_y),
        .o_out_vel_z (o_out_vel_z),
        .o_fill_end  (o_fill_end)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow store
    // ------------------------------------------------------------------------

    // A segment bound above capacity is taken as capacity.
    function automatic t_bound clamp_cap(t_bound v);
        return (v > CAPACITY) ? t_bound'(CAPACITY) : v;
    endfunction

    // Species 0 always starts at slot 0. Each later species starts where
    // the register list says that the one before it ends.
    function automatic t_bound seg_lo(logic [1:0] s);
        return (s == 2'd0) ? t_bound'(0) : clamp_cap(cfg_shadow[s - 2'd1]);
    endfunction

    function automatic t_bound seg_hi(logic [1:0] s);
        return clamp_cap(cfg_shadow[s]);
    endfunction

    function automatic void rewind_fills();
        for (int s = 0; s < NUM_SPECIES; s++) begin
            fill_ptr[s] = seg_lo(2'(s));
        end
    endfunction

    // Applies one beat to the shadow store and returns the result that the
    // block should give. An add fails when the fill has reached the segment
    // end, which also covers empty and inverted segments. A cut needs an
    // index inside [segment start, fill). It hands back the record and then
    // moves the species' last record into the freed slot.
    function automatic t_store_reply apply_particle_op(t_particle_op op);
        t_store_reply r;
        t_bound       lo;
        t_bound       hi;
        t_bound       f;
        r  = '0;
        lo = seg_lo(op.species);
        hi = seg_hi(op.species);
        f  = fill_ptr[op.species];
        r.status = STAT_DONE;
        if (op.func == FUNC_ADD) begin
            if (f >= hi || f >= CAPACITY) begin
                r.status = STAT_FULL;
            end else begin
                rec_mem[f]           = op.words;
                fill_ptr[op.species] = f + 11'd1;
            end
        end else begin
            if (op.index < lo || op.index >= f) begin
                r.status = STAT_BAD;
            end else begin
                r.words              = rec_mem[op.index];
                rec_mem[op.index]    = rec_mem[f - 11'd1];
                fill_ptr[op.species] = f - 11'd1;
            end
        end
        r.fill_end = fill_ptr[op.species];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [5:0][63:0] random_words();
        logic [5:0][63:0] w;
        for (int d = 0; d < 6; d++) begin
            w[d] = {$urandom, $urandom};
        end
        return w;
    endfunction

    // Random beat. Most cuts pick a filled slot of their species. The rest
    // hit the fill end, the slot just below the segment, or any slot at all.
    function automatic t_particle_op random_op();
        t_particle_op op;
        t_bound       lo;
        t_bound       f;
        int           pick;
        op.species = 2'($urandom_range(0, 3));
        op.words   = random_words();
        op.func    = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_CUT;
        lo   = seg_lo(op.species);
        f    = fill_ptr[op.species];
        pick = $urandom_range(0, 99);
        if (pick < 70 && f > lo) begin
            op.index = 10'($urandom_range(int'(f) - 1, int'(lo)));
        end else if (pick < 80) begin
            op.index = 10'(f);
        end else if (pick < 85) begin
            op.index = 10'(int'(lo) - 1);
        end else begin
            op.index = 10'($urandom_range(0, 1023));
        end
        return op;
    endfunction

    // Register layouts for the random phases: the reset one, small packed
    // segments anywhere in the store, any 11-bit values at all, and a
    // last segment that runs into the top of the store.
    function automatic t_cfg pick_layout(t_layout lay);
        t_cfg c;
        int   base;
        case (lay)
            LAY_RESET: begin
                c = CFG_RESET;
            end
            LAY_PACKED: begin
                base        = $urandom_range(0, 960);
                c[REG_SEG1] = t_bound'(base + $urandom_range(0, 16));
                c[REG_SEG2] = c[REG_SEG1] + t_bound'($urandom_range(0, 16));
                c[REG_SEG3] = c[REG_SEG2] + t_bound'($urandom_range(0, 16));
                c[REG_END]  = c[REG_SEG3] + t_bound'($urandom_range(0, 16));
            end
            LAY_WILD: begin
                c[REG_SEG1] = t_bound'($urandom_range(0, BOUND_MAX));
                c[REG_SEG2] = t_bound'($urandom_range(0, BOUND_MAX));
                c[REG_SEG3] = t_bound'($urandom_range(0, BOUND_MAX));
                c[REG_END]  = t_bound'($urandom_range(0, BOUND_MAX));
            end
            default: begin
                c[REG_SEG1] = t_bound'($urandom_range(0, 20));
                c[REG_SEG2] = c[REG_SEG1] + t_bound'($urandom_range(0, 20));
                c[REG_SEG3] = t_bound'($urandom_range(1000, CAPACITY - 1));
                c[REG_END]  = t_bound'($urandom_range(CAPACITY, BOUND_MAX));
            end
        endcase
        return c;
    endfunction

    // Drops valid and waits until every result beat owed has come back.
    // A short idle time follows so that the block is really at rest.
    task automatic settle_store();
        i_in_valid <= 1'b0;
        while (awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register. The caller drops the write enable once the
    // group of writes is done, so two writes in a row keep it high.
    task automatic write_reg(logic [1:0] idx, t_bound val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        cfg_shadow[idx] = val;
        rewind_fills();
    endtask

    task automatic write_layout(t_cfg c);
        settle_store();
        write_reg(REG_SEG1, c[REG_SEG1]);
        write_reg(REG_SEG2, c[REG_SEG2]);
        write_reg(REG_SEG3, c[REG_SEG3]);
        write_reg(REG_END, c[REG_END]);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one beat. A random gap may come first. The beat is accepted on
    // the first edge where the store does not stall. At that point its
    // result is predicted and queued. A typed result takes the place of the
    // predicted one, but the shadow store is still updated.
    task automatic issue_op(t_particle_op op, logic typed, t_store_reply typed_reply);
        t_store_reply pred;
        if (!no_idle && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op.func;
        i_species  <= op.species;
        i_index    <= op.index;
        i_pos_x    <= op.words[0];
        i_pos_y    <= op.words[1];
        i_pos_z    <= op.words[2];
        i_vel_x    <= op.words[3];
        i_vel_y    <= op.words[4];
        i_vel_z    <= op.words[5];
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        pred = apply_particle_op(op);
        awaited.push_back(typed ? typed_reply : pred);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each accepted beat and stall now and then
    // ------------------------------------------------------------------------

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_store_reply     want;
        logic [5:0][63:0] seen;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (awaited.size() == 0) begin
                $display("%0t: result beat expected none actual status %h fill_end %0d",
                         $time, o_status, o_fill_end);
                mismatch_cnt++;
            end else begin
                want = awaited.pop_front();
                seen = {o_out_vel_z, o_out_vel_y, o_out_vel_x,
                        o_out_pos_z, o_out_pos_y, o_out_pos_x};
                compare_field("status", want.status, o_status);
                for (int d = 0; d < 6; d++) begin
                    compare_field(WORD_NAME[d], want.words[d], seen[d]);
                end
                compare_field("fill_end", want.fill_end, o_fill_end);
            end
        end
        // Random stall runs, each started with a chance of about 3 in 100.
        if (stall_left != 0) begin
            stall_left--;
        end else if (!no_idle && $urandom_range(0, 99) < 3) begin
            stall_left = $urandom_range(1, 6);
        end
        i_out_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        t_dir_row     row;
        t_particle_op op;
        t_store_reply typed_reply;
        logic         cfg_open;
        int           issued;
        int           phase;
        int           n_ops;
        t_layout      lay;

        cfg_shadow = CFG_RESET;
        rewind_fills();
        cfg_open = 1'b0;
        issued   = 0;
        phase    = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. A run of register rows is preceded by a settle.
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.kind == ROW_CFG) begin
                if (!cfg_open) begin
                    settle_store();
                end
                write_reg(row.reg_sel, row.reg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                op.func    = row.func;
                op.species = row.species;
                op.index   = row.index;
                case (row.pat)
                    FILL_ZERO: op.words = '0;
                    FILL_ONES: op.words = '1;
                    default:   op.words = random_words();
                endcase
                typed_reply          = '0;
                typed_reply.status   = row.want_status;
                typed_reply.fill_end = row.want_fill;
                issue_op(op, row.typed, typed_reply);
            end
        end

        // Random phases. The first four walk every layout once. Phase 2
        // runs with no idle cycles on either side. After that, small packed
        // segments come most often, because they fill up and empty out.
        while (issued < RAND_ITEMS) begin
            if (phase < 4) begin
                lay = t_layout'(phase);
            end else if ($urandom_range(0, 9) < 6) begin
                lay = LAY_PACKED;
            end else begin
                lay = t_layout'($urandom_range(0, 3));
            end
            write_layout(pick_layout(lay));
            no_idle = (phase == 2);
            n_ops   = $urandom_range(80, 160);
            repeat (n_ops) begin
                // Now and then the sender holds until the store has drained.
                if ($urandom_range(0, 149) == 0) begin
                    settle_store();
                end
                issue_op(random_op(), 1'b0, '0);
                issued++;
            end
            phase++;
        end
        no_idle = 1'b0;

        settle_store();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> segmented_particle_store_top.f
hdl/sps_pkg.sv
hdl/sps_ram.sv
hdl/sps_alu.sv
hdl/sps_seq.sv
hdl/segmented_particle_store_top.sv
verif/tb_segmented_particle_store_top.sv
